/* sv/crot_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crot_pkg
// Shared types, widths and helpers for the circle/rectangle overlap tester.
// ----------------------------------------------------------------------------
package crot_pkg;

  // Coordinate width, signed Q12.4 at the default; valid range 8..32.
  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned RW   = CW - 1;          // radius width
  localparam int unsigned DW   = CW + 1;          // coordinate difference
  localparam int unsigned SQW  = 2 * DW;          // sum of two squares, unsigned
  localparam int unsigned DOTW = 2 * CW + 3;      // dot or cross product, signed
  localparam int unsigned MH   = DW;              // multiplier half width
  localparam int unsigned LW   = 4 * MH;          // full product width

  // Queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic        [RW-1:0] radius;
    logic signed [CW-1:0] corner_a_x;
    logic signed [CW-1:0] corner_a_y;
    logic signed [CW-1:0] corner_b_x;
    logic signed [CW-1:0] corner_b_y;
    logic signed [CW-1:0] corner_c_x;
    logic signed [CW-1:0] corner_c_y;
    logic signed [CW-1:0] corner_d_x;
    logic signed [CW-1:0] corner_d_y;
  } in_t;

  typedef struct packed {
    logic overlap;
    logic center_inside;
  } out_t;

  // Queued item: center relative to each corner, and each edge vector.
  // Corner index 0..3 is A..D; edge e runs from corner e to corner e+1.
  typedef struct packed {
    logic [3:0][DW-1:0] qx;
    logic [3:0][DW-1:0] qy;
    logic [3:0][DW-1:0] sx;
    logic [3:0][DW-1:0] sy;
    logic [RW-1:0]      radius;
  } item_t;

  function automatic logic signed [2*DW-1:0] smul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    return a * b;
  endfunction

endpackage

/* sv/circle_rectangle_overlap_test_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_rectangle_overlap_test_core
// Circle versus four-corner rectangle overlap tester, one query per cycle while results are popped.
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  query    | push / full        | circle center, radius, corners A..D
//  result   | empty / pop        | overlap, center_inside
//
//  One query per cycle sustained while results are popped; each query passes
//  the queue, the back-end stage registers and the result register in order.
//  A four-entry queue separates front and back; while a result waits for pop
//  the back end holds and the queue fills, raising full once four queries wait.
//  Reset (rst, synchronous) empties queue and pipeline; no other state.
//
module circle_rectangle_overlap_test_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  crot_pkg::in_t     query,
  output logic              empty,
  input  logic              pop,
  output crot_pkg::out_t    result
);

  crot_pkg::item_t head;
  crot_pkg::out_t  back_res;
  logic            avail;
  logic            back_valid;
  logic            go;
  logic            res_valid;

  // Advance the whole back pipeline whenever the result slot is free or drains.
  assign go    = !res_valid || pop;
  assign empty = !res_valid;

  // Front: transfer queries in, form difference vectors, queue them.
  crot_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .query (query),
    .take  (go),
    .avail (avail),
    .head  (head)
  );

  // Back: products, classification, segment-distance compare.
  crot_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (go),
    .in_valid  (avail),
    .item      (head),
    .res_valid (back_valid),
    .res       (back_res)
  );

  // Hold the finished result until popped.
  always_ff @(posedge clk) begin
    if (go) begin
      result <= back_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= back_valid;
    end
  end

  // A finished item moving into a free slot must show as a result.
  a_load : assert property (@(posedge clk) disable iff (rst)
    go && back_valid |=> !empty)
    else $error("finished item not presented");

  // With nothing behind it, popping the last result leaves the port empty.
  a_drain : assert property (@(posedge clk) disable iff (rst)
    pop && !empty && !back_valid |=> empty)
    else $error("result repeated after pop");

  // Reset leaves both sides idle.
  a_reset : assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("not idle after reset");

endmodule

/* sv/crot_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crot_mul
// Two-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module crot_mul (
  input  logic                            clk,
  input  logic                            en,
  input  logic [2*crot_pkg::MH-1:0]       a,
  input  logic [2*crot_pkg::MH-1:0]       b,
  output logic [crot_pkg::LW-1:0]         p
);

  localparam int unsigned H = crot_pkg::MH;

  logic [2*H-1:0] hh, hl, lh, ll;

  always_ff @(posedge clk) begin
    if (en) begin
      hh <= a[2*H-1:H] * b[2*H-1:H];
      hl <= a[2*H-1:H] * b[H-1:0];
      lh <= a[H-1:0]   * b[2*H-1:H];
      ll <= a[H-1:0]   * b[H-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (crot_pkg::LW'(hh) << (2 * H)) + (crot_pkg::LW'(hl) << H)
         + (crot_pkg::LW'(lh) << H) + crot_pkg::LW'(ll);
    end
  end

endmodule

/* sv/crot_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crot_front
// Accept queries, form corner and edge difference vectors, queue them.
// ----------------------------------------------------------------------------
module crot_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  crot_pkg::in_t       query,
  input  logic                take,
  output logic                avail,
  output crot_pkg::item_t     head
);

  localparam int unsigned DW  = crot_pkg::DW;
  localparam int unsigned QAW = crot_pkg::QAW;

  crot_pkg::item_t mem [crot_pkg::QDEPTH];
  crot_pkg::item_t item_next;
  logic [QAW-1:0]  wptr, rptr;
  logic [QAW:0]    count;
  logic            wr, rd;
  logic [3:0][DW-1:0] cx, cy;

  assign full  = (count == (QAW+1)'(crot_pkg::QDEPTH));
  assign avail = (count != '0);
  assign wr    = push && !full;
  assign rd    = take && avail;
  assign head  = mem[rptr];

  always_comb begin
    cx[0] = DW'(query.corner_a_x);
    cy[0] = DW'(query.corner_a_y);
    cx[1] = DW'(query.corner_b_x);
    cy[1] = DW'(query.corner_b_y);
    cx[2] = DW'(query.corner_c_x);
    cy[2] = DW'(query.corner_c_y);
    cx[3] = DW'(query.corner_d_x);
    cy[3] = DW'(query.corner_d_y);
    item_next.radius = query.radius;
    for (int i = 0; i < 4; i++) begin
      item_next.qx[i] = DW'(query.center_x) - cx[i];
      item_next.qy[i] = DW'(query.center_y) - cy[i];
      item_next.sx[i] = cx[2'(i + 1)] - cx[i];
      item_next.sy[i] = cy[2'(i + 1)] - cy[i];
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end

endmodule

/* sv/crot_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crot_back
// Three-stage evaluation: products, edge classification, segment distance.
// ----------------------------------------------------------------------------
module crot_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  crot_pkg::item_t     item,
  output logic                res_valid,
  output crot_pkg::out_t      res
);

  localparam int unsigned DW   = crot_pkg::DW;
  localparam int unsigned SQW  = crot_pkg::SQW;
  localparam int unsigned DOTW = crot_pkg::DOTW;
  localparam int unsigned RW   = crot_pkg::RW;
  localparam int unsigned LW   = crot_pkg::LW;

  typedef struct packed {
    logic [3:0][SQW-1:0]  qq;
    logic [3:0][SQW-1:0]  len2;
    logic [3:0][DOTW-1:0] t;
    logic [3:0][DOTW-1:0] xprod;
    logic [DOTW-1:0]      pad;
    logic [2*RW-1:0]      r2;
  } s1_t;

  typedef struct packed {
    logic [3:0] endt;
    logic [3:0] mid;
    logic       in_rect;
  } flags_t;

  s1_t    s1, s1_next;
  flags_t s2, s2_next, s3;
  logic   v1, v2, v3;
  logic [3:0][SQW-1:0] cm;
  logic [3:0][LW-1:0]  lhs, rhs;
  logic [3:0]          touch;

  // Stage 1: dot, cross and square products of the difference vectors and radius.
  always_comb begin
    logic signed [DOTW-1:0] p;
    for (int e = 0; e < 4; e++) begin
      s1_next.qq[e]   = $unsigned(crot_pkg::smul($signed(item.qx[e]), $signed(item.qx[e])))
                      + $unsigned(crot_pkg::smul($signed(item.qy[e]), $signed(item.qy[e])));
      s1_next.len2[e] = $unsigned(crot_pkg::smul($signed(item.sx[e]), $signed(item.sx[e])))
                      + $unsigned(crot_pkg::smul($signed(item.sy[e]), $signed(item.sy[e])));
      s1_next.t[e]    = DOTW'(crot_pkg::smul($signed(item.qx[e]), $signed(item.sx[e])))
                      + DOTW'(crot_pkg::smul($signed(item.qy[e]), $signed(item.sy[e])));
      s1_next.xprod[e] = DOTW'(crot_pkg::smul($signed(item.qx[e]), $signed(item.sy[e])))
                       - DOTW'(crot_pkg::smul($signed(item.qy[e]), $signed(item.sx[e])));
    end
    // Projection onto A->D is the negated dot with edge D->A.
    p = DOTW'(crot_pkg::smul($signed(item.qx[0]), $signed(item.sx[3])))
      + DOTW'(crot_pkg::smul($signed(item.qy[0]), $signed(item.sy[3])));
    s1_next.pad = -p;
    s1_next.r2  = item.radius * item.radius;
  end

  // Stage 2: pick nearest-point case per edge and the inside test.
  always_comb begin
    logic [SQW-1:0] r2e;
    logic zl, tle0, far;
    r2e = SQW'(s1.r2);
    for (int e = 0; e < 4; e++) begin
      zl   = (s1.len2[e] == '0);
      tle0 = ($signed(s1.t[e]) <= 0);
      far  = ($signed({1'b0, s1.len2[e]}) <= $signed(s1.t[e]));
      cm[e] = $signed(s1.xprod[e]) < 0 ? SQW'(-s1.xprod[e]) : SQW'(s1.xprod[e]);
      if (zl || tle0) begin
        s2_next.endt[e] = (s1.qq[e] <= r2e);
        s2_next.mid[e]  = 1'b0;
      end else if (far) begin
        s2_next.endt[e] = (s1.qq[2'(e + 1)] <= r2e);
        s2_next.mid[e]  = 1'b0;
      end else begin
        s2_next.endt[e] = 1'b0;
        s2_next.mid[e]  = 1'b1;
      end
    end
    s2_next.in_rect = (s1.len2[0] != '0) && (s1.len2[3] != '0)
                   && ($signed(s1.t[0]) >= 0)
                   && ($signed({1'b0, s1.len2[0]}) >= $signed(s1.t[0]))
                   && ($signed(s1.pad) >= 0)
                   && ($signed({1'b0, s1.len2[3]}) >= $signed(s1.pad));
  end

  for (genvar e = 0; e < 4; e++) begin : g_edge
    crot_mul u_cc (
      .clk (clk),
      .en  (en),
      .a   (cm[e]),
      .b   (cm[e]),
      .p   (lhs[e])
    );
    crot_mul u_rl (
      .clk (clk),
      .en  (en),
      .a   (SQW'(s1.r2)),
      .b   (s1.len2[e]),
      .p   (rhs[e])
    );
    assign touch[e] = s3.mid[e] ? (lhs[e] <= rhs[e]) : s3.endt[e];
  end

  assign res.overlap       = s3.in_rect || (touch != '0);
  assign res.center_inside = s3.in_rect;
  assign res_valid         = v3;

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      s3 <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

endmodule
